/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define PFH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfh assertion failed");

// property checked at every edge, reset included
`define PFH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pfh assertion failed");

`endif

/* rtl/pfh_pkg.sv */
// ----------------------------------------------------------------------------
// pfh_pkg
// shared types and constants of the prime factor histogram core
// ----------------------------------------------------------------------------
`default_nettype none
package pfh_pkg;

    localparam int MAX_VALUE_DEF  = 65536;
    localparam int COUNT_BITS_DEF = 17;
    localparam int IN_W           = 16;
    localparam int OUT_W          = 20;
    localparam logic [OUT_W-1:0] CNT_OUT_MAX = 20'hFFFFF;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_ZERO  = 2'd2
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [IN_W-1:0] value;
        logic [IN_W-1:0] lo;
        logic [IN_W-1:0] hi;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage
`default_nettype wire

/* rtl/pfh_if.sv */
// ----------------------------------------------------------------------------
// pfh_in_if / pfh_out_if
// valid/ready channels of the core
// ----------------------------------------------------------------------------
`default_nettype none
interface pfh_in_if;
    import pfh_pkg::*;
    logic            valid;
    logic            ready;
    logic            kind;
    logic [IN_W-1:0] value;
    logic [IN_W-1:0] range_low;
    logic [IN_W-1:0] range_high;
    modport source (output valid, kind, value, range_low, range_high, input ready);
    modport sink   (input valid, kind, value, range_low, range_high, output ready);
endinterface

interface pfh_out_if;
    import pfh_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] count;
    modport source (output valid, count, input ready);
    modport sink   (input valid, count, output ready);
endinterface
`default_nettype wire

/* rtl/prime_factor_histogram_range_count_core.sv */
// ----------------------------------------------------------------------------
// prime_factor_histogram_range_count_core
// distinct prime factor histogram with range-count queries
// ----------------------------------------------------------------------------
//  channel  dir  payload                            beat per item
//  i_in     in   kind, value, range_low, range_high one load or query
//  o_out    out  count                              one per query
//
//  after reset a clearing pass over every table entry and tree node, then a
//  sieve pass that reads each table entry visited by a sieve prime and
//  writes it if still unmarked; a load takes a start step, a read and a
//  test per table step, and for each distinct prime a read and a test of
//  its count followed by the read/write update loop of the single-port
//  tree; a query walks the indexed tree from the high bound and then from
//  the low bound
//  input beats queue two deep during the passes and while the back is busy
// ----------------------------------------------------------------------------
`default_nettype none
module prime_factor_histogram_range_count_core #(
    parameter int MAX_VALUE  = pfh_pkg::MAX_VALUE_DEF,
    parameter int COUNT_BITS = pfh_pkg::COUNT_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfh_in_if.sink     i_in,
    pfh_out_if.source  o_out
);
    import pfh_pkg::*;

    t_push w_push;      // classified beat into the queue
    logic  w_full;
    logic  w_q_valid;
    t_cmd  w_q_cmd;
    logic  w_pop;

    // front: takes beats, drops loads that change nothing
    pfh_front #(.MAX_VALUE(MAX_VALUE)) u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push)
    );

    // short queue decouples acceptance from the sequencer
    pfh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    // back: sieve, factoring and tree histogram, output register
    pfh_back #(.MAX_VALUE(MAX_VALUE), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

/* rtl/pfh_front.sv */
// ----------------------------------------------------------------------------
// pfh_front
// accepts input beats and sorts them into work commands
// ----------------------------------------------------------------------------
`default_nettype none
module pfh_front #(
    parameter int MAX_VALUE = pfh_pkg::MAX_VALUE_DEF
) (
    pfh_in_if.sink        i_in,
    input  wire logic     i_full,
    output pfh_pkg::t_push o_push
);
    import pfh_pkg::*;

    assign i_in.ready = !i_full;

    always_comb begin
        o_push.valid     = 1'b0;
        o_push.cmd.op    = OP_LOAD;
        o_push.cmd.value = i_in.value;
        o_push.cmd.lo    = i_in.range_low;
        o_push.cmd.hi    = i_in.range_high;
        if (i_in.valid && i_in.ready) begin
            if (i_in.kind == KIND_LOAD) begin
                // zero, one and out-of-table values leave the histogram alone
                o_push.valid = (i_in.value >= IN_W'(2)) && (32'(i_in.value) < MAX_VALUE);
            end else begin
                o_push.valid = 1'b1;
                if ((i_in.range_low > i_in.range_high) || (32'(i_in.range_low) >= MAX_VALUE)) begin
                    o_push.cmd.op = OP_ZERO;
                end else begin
                    o_push.cmd.op = OP_QUERY;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/pfh_queue.sv */
// ----------------------------------------------------------------------------
// pfh_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module pfh_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  pfh_pkg::t_push     i_push,
    output logic               o_full,
    output logic               o_valid,
    output pfh_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import pfh_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) r_wp <= !r_wp;
            if (w_pop)        r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

/* rtl/pfh_back.sv */
// ----------------------------------------------------------------------------
// pfh_back
// sieve table, factoring sequencer and indexed-tree histogram
// ----------------------------------------------------------------------------
`default_nettype none
module pfh_back #(
    parameter int MAX_VALUE  = pfh_pkg::MAX_VALUE_DEF,
    parameter int COUNT_BITS = pfh_pkg::COUNT_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_valid,
    input  pfh_pkg::t_cmd  i_q_cmd,
    output logic           o_pop,
    pfh_out_if.source      o_out
);
    import pfh_pkg::*;

    localparam int AB = $clog2(MAX_VALUE);       // table address
    localparam int IB = $clog2(MAX_VALUE + 1);   // tree index 0..N
    localparam int PB = (AB + 1) / 2;            // smallest factor of a composite
    localparam int SB = AB + 2;                  // square of sieve prime
    localparam int AW = COUNT_BITS + AB;         // tree node / query sum
    localparam int EW = PB + AB;                 // sieve entry {factor, cofactor}

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_SV_CHK = 15'b000000000000010,
        S_SV_TST = 15'b000000000000100,
        S_MK_RD  = 15'b000000000001000,
        S_MK_WR  = 15'b000000000010000,
        S_IDLE   = 15'b000000000100000,
        S_F_RD   = 15'b000000001000000,
        S_F_TST  = 15'b000000010000000,
        S_B_RD   = 15'b000000100000000,
        S_B_TST  = 15'b000001000000000,
        S_U_RD   = 15'b000010000000000,
        S_U_WR   = 15'b000100000000000,
        S_Q_RD   = 15'b001000000000000,
        S_Q_ACC  = 15'b010000000000000,
        S_EMIT   = 15'b100000000000000
    } t_state;

    logic [EW-1:0]         spf_mem  [MAX_VALUE];
    logic [COUNT_BITS-1:0] raw_mem  [MAX_VALUE];
    logic [AW-1:0]         tree_mem [MAX_VALUE+1];

    logic [EW-1:0]         spf_q;
    logic [COUNT_BITS-1:0] raw_q;
    logic [AW-1:0]         tree_q;

    t_state r_state, n_state;
    logic [IB-1:0]   r_c, n_c;
    logic [PB:0]     r_i, n_i;
    logic [SB-1:0]   r_sq, n_sq;
    logic [AB:0]     r_j, n_j;
    logic [AB-1:0]   r_cof, n_cof;
    logic [AB-1:0]   r_x, n_x;
    logic [PB-1:0]   r_last, n_last;
    logic            r_fin, n_fin;
    logic [AB-1:0]   r_b, n_b;
    logic [IB:0]     r_idx, n_idx;
    logic [IB-1:0]   r_lo, n_lo;
    logic            r_ph, n_ph;
    logic [AW-1:0]   r_acc, n_acc;
    logic [OUT_W-1:0] r_res, n_res;
    logic            r_ov, n_ov;
    logic [OUT_W-1:0] r_count, n_count;

    logic [AB-1:0]   spf_ra, spf_wa;
    logic            spf_we;
    logic [EW-1:0]   spf_wd;
    logic            raw_we;
    logic [AB-1:0]   raw_wa;
    logic [COUNT_BITS-1:0] raw_wd;
    logic            tree_we;
    logic [IB-1:0]   tree_wa;
    logic [AW-1:0]   tree_wd;

    logic [PB-1:0]   q_p;
    logic [AB-1:0]   q_cof;
    logic [IB:0]     low_bit;
    logic [IB:0]     idx_up;
    logic [16:0]     hi_inc;
    logic [IB-1:0]   hi_p;

    assign q_p     = spf_q[EW-1:AB];
    assign q_cof   = spf_q[AB-1:0];
    assign low_bit = r_idx & (~r_idx + (IB+1)'(1));
    assign idx_up  = r_idx + low_bit;
    assign hi_inc  = {1'b0, i_q_cmd.hi} + 17'd1;
    assign hi_p    = (32'(hi_inc) >= MAX_VALUE) ? IB'(MAX_VALUE) : IB'(hi_inc);

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_out.valid = r_ov;
    assign o_out.count = r_count;

    // memories, read data registered
    always_ff @(posedge i_clk) begin
        if (spf_we)  spf_mem[spf_wa]   <= spf_wd;
        if (raw_we)  raw_mem[raw_wa]   <= raw_wd;
        if (tree_we) tree_mem[tree_wa] <= tree_wd;
        spf_q  <= spf_mem[spf_ra];
        raw_q  <= raw_mem[r_b];
        tree_q <= tree_mem[r_idx[IB-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_c = r_c;  n_i = r_i;  n_sq = r_sq;  n_j = r_j;  n_cof = r_cof;
        n_x = r_x;  n_last = r_last;  n_fin = r_fin;  n_b = r_b;
        n_idx = r_idx;  n_lo = r_lo;  n_ph = r_ph;  n_acc = r_acc;  n_res = r_res;
        n_ov = r_ov;  n_count = r_count;

        spf_ra  = r_x;
        spf_we  = 1'b0;  spf_wa = r_j[AB-1:0];  spf_wd = {PB'(r_i), r_cof};
        raw_we  = 1'b0;  raw_wa = r_b;          raw_wd = raw_q + COUNT_BITS'(1);
        tree_we = 1'b0;  tree_wa = r_idx[IB-1:0]; tree_wd = tree_q + AW'(1);

        if (r_ov && o_out.ready) n_ov = 1'b0;

        case (r_state)
            S_CLEAR: begin
                spf_wa  = r_c[AB-1:0];  spf_wd = '0;  spf_we = (32'(r_c) < MAX_VALUE);
                raw_wa  = r_c[AB-1:0];  raw_wd = '0;  raw_we = (32'(r_c) < MAX_VALUE);
                tree_wa = r_c;          tree_wd = '0; tree_we = 1'b1;
                n_c = r_c + IB'(1);
                if (r_c == IB'(MAX_VALUE)) begin
                    n_i = (PB+1)'(2);
                    n_sq = SB'(4);
                    n_state = S_SV_CHK;
                end
            end
            S_SV_CHK: begin
                spf_ra  = AB'(r_i);
                n_state = S_SV_TST;
            end
            S_SV_TST, S_MK_WR: begin
                logic adv;
                adv = 1'b0;
                if (r_state == S_SV_TST) begin
                    if (q_p != '0) begin
                        adv = 1'b1;
                    end else begin
                        n_j = (AB+1)'(r_sq);
                        n_cof = AB'(r_i);
                        n_state = S_MK_RD;
                    end
                end else begin
                    spf_we = (q_p == '0);
                    n_j = r_j + (AB+1)'(r_i);
                    n_cof = r_cof + AB'(1);
                    if (32'(n_j) >= MAX_VALUE) adv = 1'b1;
                    else n_state = S_MK_RD;
                end
                if (adv) begin
                    n_i = r_i + (PB+1)'(1);
                    n_sq = r_sq + SB'({r_i, 1'b1});
                    n_state = (32'(n_sq) >= MAX_VALUE) ? S_IDLE : S_SV_CHK;
                end
            end
            S_MK_RD: begin
                spf_ra  = r_j[AB-1:0];
                n_state = S_MK_WR;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_LOAD: begin
                            n_x = AB'(i_q_cmd.value);
                            n_last = '0;
                            n_fin = 1'b0;
                            n_state = S_F_RD;
                        end
                        OP_QUERY: begin
                            n_idx = {1'b0, hi_p};
                            n_lo = IB'(i_q_cmd.lo);
                            n_ph = 1'b0;
                            n_acc = '0;
                            n_state = S_Q_RD;
                        end
                        default: begin
                            n_res = '0;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_F_RD: begin
                spf_ra  = r_x;
                n_state = S_F_TST;
            end
            S_F_TST: begin
                if (q_p == '0) begin
                    // remaining cofactor is prime
                    n_fin = 1'b1;
                    if (r_x != AB'(r_last)) begin
                        n_b = r_x;
                        n_state = S_B_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_x = q_cof;
                    if (q_p != r_last) begin
                        n_last = q_p;
                        n_b = AB'(q_p);
                        n_state = S_B_RD;
                    end else begin
                        n_state = (q_cof < AB'(2)) ? S_IDLE : S_F_RD;
                    end
                end
            end
            S_B_RD: begin
                n_state = S_B_TST;
            end
            S_B_TST: begin
                if (raw_q == '1) begin
                    n_state = (r_fin || r_x < AB'(2)) ? S_IDLE : S_F_RD;
                end else begin
                    raw_we = 1'b1;
                    n_idx = (IB+1)'(r_b) + (IB+1)'(1);
                    n_state = S_U_RD;
                end
            end
            S_U_RD: begin
                n_state = S_U_WR;
            end
            S_U_WR: begin
                tree_we = 1'b1;
                n_idx = idx_up;
                if (32'(idx_up) > MAX_VALUE) begin
                    n_state = (r_fin || r_x < AB'(2)) ? S_IDLE : S_F_RD;
                end else begin
                    n_state = S_U_RD;
                end
            end
            S_Q_RD: begin
                if (r_idx == '0) begin
                    if (!r_ph) begin
                        n_ph = 1'b1;
                        n_idx = {1'b0, r_lo};
                    end else begin
                        n_res = (64'(r_acc) >= 64'(CNT_OUT_MAX)) ? CNT_OUT_MAX : OUT_W'(r_acc);
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_Q_ACC;
                end
            end
            S_Q_ACC: begin
                n_acc = r_ph ? (r_acc - tree_q) : (r_acc + tree_q);
                n_idx = r_idx - low_bit;
                n_state = S_Q_RD;
            end
            S_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1;
                    n_count = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_c     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_ov    <= n_ov;
        end
        r_i <= n_i;  r_sq <= n_sq;  r_j <= n_j;  r_cof <= n_cof;
        r_x <= n_x;  r_last <= n_last;  r_fin <= n_fin;  r_b <= n_b;
        r_idx <= n_idx;  r_lo <= n_lo;  r_ph <= n_ph;  r_acc <= n_acc;
        r_res <= n_res;  r_count <= n_count;
    end

endmodule
`default_nettype wire

/* rtl/pfh_checker.sv */
// ----------------------------------------------------------------------------
// pfh_checker
// port-level checks of the core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pfh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [19:0] i_out_count
);
    // a stalled result holds
    `PFH_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_count))
    // reset empties the output register
    `PFH_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid)
    // queue is empty straight after reset
    `PFH_ASSERT_ALWAYS(a_rst_rdy, i_clk, !i_rst_n |=> i_in_ready)
endmodule

bind prime_factor_histogram_range_count_core pfh_checker u_pfh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_count (o_out.count)
);
`default_nettype wire

/* tb/sv/tb_prime_factor_histogram_range_count_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_factor_histogram_range_count_core
// loads and range queries are pushed through the core in bursts with random
// gaps while the result side stalls on its own pattern; every query count is
// checked against a local histogram kept from the accepted loads
// ----------------------------------------------------------------------------
module tb_prime_factor_histogram_range_count_core;
    import pfh_pkg::*;

    localparam int TBL_SIZE   = MAX_VALUE_DEF;
    localparam int CNT_BITS   = COUNT_BITS_DEF;
    localparam int N_RANDOM   = 800;
    localparam int DRAIN_CYC  = 400;

    typedef struct {
        logic            kind;
        logic [IN_W-1:0] value;
        logic [IN_W-1:0] lo;
        logic [IN_W-1:0] hi;
    } t_beat;

    logic clk;
    logic rst_n;

    pfh_in_if  in_if ();
    pfh_out_if out_if ();

    prime_factor_histogram_range_count_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the core state
    int unsigned     spf_tab [TBL_SIZE];
    int unsigned     prime_cnt [int unsigned];
    logic [OUT_W-1:0] count_due [$];
    t_beat           beats_pending [$];

    int n_loads, n_queries, n_results, n_mismatch;
    int burst_left, gap_left;
    int rdy_mode, rdy_left, rdy_stall;

    function automatic void build_spf_table();
        for (int i = 0; i < TBL_SIZE; i++) spf_tab[i] = 0;
        for (int i = 2; i * i < TBL_SIZE; i++) begin
            if (spf_tab[i] == 0) begin
                for (int j = i * i; j < TBL_SIZE; j += i)
                    if (spf_tab[j] == 0) spf_tab[j] = i;
            end
        end
    endfunction

    function automatic void bump_prime(int unsigned p);
        int unsigned top;
        top = (1 << CNT_BITS) - 1;
        if (p >= TBL_SIZE) return;
        if (!prime_cnt.exists(p)) prime_cnt[p] = 0;
        if (prime_cnt[p] < top) prime_cnt[p]++;
    endfunction

    function automatic void add_factors(int unsigned x);
        int unsigned last, p;
        last = 0;
        if (x < 2 || x >= TBL_SIZE) return;
        forever begin
            p = spf_tab[x];
            if (p == 0) begin
                if (x != last) bump_prime(x);
                return;
            end
            if (p != last) begin
                bump_prime(p);
                last = p;
            end
            x = x / p;
            if (x < 2) return;
        end
    endfunction

    function automatic logic [OUT_W-1:0] range_count(int unsigned lo, int unsigned hi);
        longint unsigned sum;
        sum = 0;
        if (lo > hi) return '0;
        foreach (prime_cnt[k]) begin
            if (k >= lo && k <= hi) sum += prime_cnt[k];
        end
        if (sum >= CNT_OUT_MAX) return CNT_OUT_MAX;
        return sum[OUT_W-1:0];
    endfunction

    function automatic t_beat mk_beat(logic kind, int unsigned v, int unsigned lo,
                                      int unsigned hi);
        t_beat b;
        b.kind  = kind;
        b.value = v[IN_W-1:0];
        b.lo    = lo[IN_W-1:0];
        b.hi    = hi[IN_W-1:0];
        return b;
    endfunction

    // append one beat to the pending list
    function automatic void queue_beat(t_beat b);
        beats_pending = {beats_pending, b};
    endfunction

    // driver: bursts of beats separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (in_if.kind == KIND_LOAD) begin
                    add_factors(in_if.value);
                    n_loads++;
                end else begin
                    count_due = {count_due, range_count(in_if.range_low, in_if.range_high)};
                    n_queries++;
                end
                void'(beats_pending.pop_front());
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0 || beats_pending.size() == 0) begin
                    in_if.valid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    in_if.valid      <= 1'b1;
                    in_if.kind       <= beats_pending[0].kind;
                    in_if.value      <= beats_pending[0].value;
                    in_if.range_low  <= beats_pending[0].lo;
                    in_if.range_high <= beats_pending[0].hi;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        // zero gap now and then gives back-to-back bursts
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // monitor: ready pattern switches between always on, dithered and long stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            rdy_mode     <= 0;
            rdy_left     <= 0;
            rdy_stall    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (count_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result beat: count %0d", out_if.count);
                end else begin
                    if (out_if.count !== count_due[0]) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("count mismatch: expected %0d, got %0d",
                                     count_due[0], out_if.count);
                    end
                    void'(count_due.pop_front());
                end
            end
            if (rdy_left == 0) begin
                rdy_mode  <= $urandom_range(0, 2);
                rdy_left  <= $urandom_range(64, 600);
            end else begin
                rdy_left <= rdy_left - 1;
            end
            case (rdy_mode)
                0: begin
                    out_if.ready <= 1'b1;
                end
                1: begin
                    out_if.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if (rdy_stall > 0) begin
                        rdy_stall    <= rdy_stall - 1;
                        out_if.ready <= 1'b0;
                    end else begin
                        rdy_stall    <= $urandom_range(0, 60);
                        out_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin
        int unsigned lo, hi, v;
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_LOAD;
        in_if.value      = '0;
        in_if.range_low  = '0;
        in_if.range_high = '0;
        out_if.ready     = 1'b0;
        n_loads = 0; n_queries = 0; n_results = 0; n_mismatch = 0;
        build_spf_table();

        // directed: zero and one add nothing, repeated primes, large prime, extremes
        queue_beat(mk_beat(KIND_QUERY, 0, 0, 65535));
        queue_beat(mk_beat(KIND_LOAD, 0, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 1, 0, 0));
        queue_beat(mk_beat(KIND_QUERY, 65535, 0, 65535));
        queue_beat(mk_beat(KIND_LOAD, 2, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 4, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 32768, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 30030, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 65521, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 65535, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 65534, 0, 0));
        queue_beat(mk_beat(KIND_LOAD, 49, 0, 0));
        queue_beat(mk_beat(KIND_QUERY, 0, 2, 2));
        queue_beat(mk_beat(KIND_QUERY, 0, 0, 1));
        queue_beat(mk_beat(KIND_QUERY, 0, 3, 13));
        queue_beat(mk_beat(KIND_QUERY, 0, 65521, 65535));
        queue_beat(mk_beat(KIND_QUERY, 0, 65535, 65535));
        // empty ranges, then the full range
        queue_beat(mk_beat(KIND_QUERY, 0, 100, 99));
        queue_beat(mk_beat(KIND_QUERY, 0, 65535, 0));
        queue_beat(mk_beat(KIND_QUERY, 0, 0, 65535));

        for (int n = 0; n < N_RANDOM; n++) begin
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
            if ($urandom_range(0, 99) < 60) begin
                queue_beat(mk_beat(KIND_LOAD, v, $urandom_range(0, 65535),
                                   $urandom_range(0, 65535)));
            end else begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
                case ($urandom_range(0, 4))
                    0: begin lo = $urandom_range(0, 64); hi = lo + $urandom_range(0, 200); end
                    1: begin if (lo > hi) begin v = lo; lo = hi; hi = v; end end
                    2: begin lo = $urandom_range(0, 1000); hi = 65535; end
                    default: ;
                endcase
                queue_beat(mk_beat(KIND_QUERY, $urandom_range(0, 65535), lo, hi));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (beats_pending.size() == 0 && !in_if.valid);
        wait (count_due.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("run covered %0d loads and %0d range queries, %0d counts checked",
                 n_loads, n_queries, n_results);
        if (n_mismatch == 0 && count_due.size() == 0) begin
            $display("tb_prime_factor_histogram_range_count_core: clean");
        end else begin
            $display("%0d mismatches, %0d counts outstanding", n_mismatch, count_due.size());
            $display("tb_prime_factor_histogram_range_count_core: errors");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("timeout waiting for the core");
        $display("tb_prime_factor_histogram_range_count_core: errors");
        $finish;
    end

endmodule
